// ----- hdl/gscc_pkg.sv -----
// Shared definitions for the graph strong connectivity check unit.
// Holds field widths, reset constants and the adjacency RAM control struct.
// Depends on nothing; every other file of the unit refers to it by scoped names.
package gscc_pkg;

    // Default and upper bound for the number of graph nodes.
    localparam int MAX_NODES_DEF = 64;

    // Fixed field widths of the stream and configuration ports.
    localparam int NODE_FIELD_W = 6;
    localparam int COUNT_W      = 7;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 16;

    // Reset value of the node count register.
    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

    // Control group from the sequencer to the adjacency RAM.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear_all;
    } ram_ctl_t;

endpackage

// ----- hdl/gscc_adj_ram.sv -----
// Adjacency bit matrix storage: one row per source node, one read and one write port.
// Per-row valid bits make a cleared row read as zero without a sweep.
// Depends on gscc_pkg for the control struct.
module gscc_adj_ram #(
    parameter int MAX_NODES = gscc_pkg::MAX_NODES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gscc_pkg::ram_ctl_t           ctl,
    input  logic [$clog2(MAX_NODES)-1:0] rd_addr,
    input  logic [$clog2(MAX_NODES)-1:0] wr_addr,
    input  logic [MAX_NODES-1:0]         wr_data,
    output logic [MAX_NODES-1:0]         rd_data
);

    logic [MAX_NODES-1:0] mem [MAX_NODES];
    logic [MAX_NODES-1:0] row_valid_reg;
    logic [MAX_NODES-1:0] rd_data_reg;
    logic                 rd_valid_reg;

    // Row storage and registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Row valid bits: set on write, all dropped at once on clear.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.clear_all)
            begin
                row_valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    // A row that was never written since the last clear reads as empty.
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- hdl/gscc_reach_unit.sv -----
// Shared reachability step: folds one adjacency row into both visited sets.
// Forward: a visited source adds its row; reverse: a row hitting the set adds its node.
// Depends on gscc_pkg for the default node limit.
module gscc_reach_unit #(
    parameter int MAX_NODES = gscc_pkg::MAX_NODES_DEF
) (
    input  logic [MAX_NODES-1:0]         row,
    input  logic [$clog2(MAX_NODES)-1:0] row_idx,
    input  logic [MAX_NODES-1:0]         node_mask,
    input  logic [MAX_NODES-1:0]         seen_fwd,
    input  logic [MAX_NODES-1:0]         seen_rev,
    output logic [MAX_NODES-1:0]         seen_fwd_next,
    output logic [MAX_NODES-1:0]         seen_rev_next,
    output logic                         changed
);

    logic [MAX_NODES-1:0] row_bit;
    logic                 fwd_hit;
    logic                 rev_hit;

    assign row_bit = MAX_NODES'(1) << row_idx;

    // Forward walk follows the row's out-edges; reverse walk marks the row's node.
    assign fwd_hit       = seen_fwd[row_idx];
    assign rev_hit       = |(row & seen_rev);
    assign seen_fwd_next = fwd_hit ? (seen_fwd | (row & node_mask)) : seen_fwd;
    assign seen_rev_next = rev_hit ? (seen_rev | row_bit) : seen_rev;
    assign changed       = (seen_fwd_next != seen_fwd) || (seen_rev_next != seen_rev);

endmodule

// ----- hdl/graph_strong_connectivity_check_unit.sv -----
// Top level of the graph strong connectivity check unit: sequencer, counters, ports.
// Instantiates gscc_adj_ram and gscc_reach_unit; uses gscc_pkg for widths and types.
//
// Channel   | Direction | Signals                              | Contents
// s_axis    | in        | tvalid tready tdata[15:0] tlast      | one directed edge, tlast ends graph
// m_axis    | out       | tvalid tready tdata[15:0]            | connectivity result
// cfg       | in        | cfg_wr_en cfg_wr_data[6:0]           | node_count register
//
// A stored edge needs a row read, then a row write; an ignored edge is only accepted.
// After the last edge the walk sweeps rows 0..n-1 repeatedly through the single RAM
// read port, one row per cycle, until a full sweep adds nothing. The visited sets are
// then counted node by node.
// Reset clears the row valid bits at once; there is no clearing pass.
// A pending result waits in the output register; a new edge is taken meanwhile.
module graph_strong_connectivity_check_unit #(
    parameter int MAX_NODES = gscc_pkg::MAX_NODES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input edge transfer.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: [5:0] source_node, [11:6] dest_node, [15:12] zero.
    input  logic [gscc_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // tlast: last_edge.
    input  logic                                s_axis_tlast,
    // Result transfer.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: [0] is_strongly_connected, [7:1] forward_reached,
    //        [14:8] reverse_reached, [15] bad_edge_seen.
    output logic [gscc_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // Configuration: node_count.
    input  logic                                cfg_wr_en,
    input  logic [gscc_pkg::COUNT_W-1:0]        cfg_wr_data
);

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int FIELD_W = gscc_pkg::NODE_FIELD_W;
    localparam int CNT_W   = gscc_pkg::COUNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_WALK,
        ST_COUNT,
        ST_FINISH
    } state_t;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           node_count_reg, node_count_next;
    logic [NODE_W-1:0]          src_reg, src_next;
    logic [NODE_W-1:0]          dst_reg, dst_next;
    logic                       last_reg, last_next;
    logic                       bad_reg, bad_next;
    logic [NODE_W-1:0]          walk_idx_reg, walk_idx_next;
    logic                       proc_valid_reg, proc_valid_next;
    logic [NODE_W-1:0]          proc_idx_reg, proc_idx_next;
    logic                       changed_reg, changed_next;
    logic [MAX_NODES-1:0]       seen_fwd_reg, seen_fwd_next;
    logic [MAX_NODES-1:0]       seen_rev_reg, seen_rev_next;
    logic [NODE_W-1:0]          cnt_idx_reg, cnt_idx_next;
    logic [CNT_W-1:0]           fwd_cnt_reg, fwd_cnt_next;
    logic [CNT_W-1:0]           rev_cnt_reg, rev_cnt_next;
    logic                       m_valid_reg, m_valid_next;
    logic [gscc_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic [CNT_W-1:0]           eff_n;
    logic [CNT_W-1:0]           last_idx;
    logic [MAX_NODES-1:0]       node_mask;
    logic [FIELD_W-1:0]         in_src;
    logic [FIELD_W-1:0]         in_dst;
    logic                       in_accept;
    logic                       in_good;

    gscc_pkg::ram_ctl_t         ram_ctl;
    logic [NODE_W-1:0]          ram_rd_addr;
    logic [MAX_NODES-1:0]       ram_wr_data;
    logic [MAX_NODES-1:0]       ram_rd_data;

    logic [MAX_NODES-1:0]       unit_fwd;
    logic [MAX_NODES-1:0]       unit_rev;
    logic                       unit_changed;
    logic                       out_free;

    // Effective node count: zero acts as one, anything above the array acts as its size.
    always_comb
    begin
        if (node_count_reg == '0)
        begin
            eff_n = CNT_W'(1);
        end
        else if (node_count_reg > CNT_W'(MAX_NODES))
        begin
            eff_n = CNT_W'(MAX_NODES);
        end
        else
        begin
            eff_n = node_count_reg;
        end
    end

    assign last_idx = eff_n - CNT_W'(1);

    // Nodes below the effective count.
    always_comb
    begin
        for (int k = 0; k < MAX_NODES; k++)
        begin
            node_mask[k] = (CNT_W'(k) < eff_n);
        end
    end

    // Input edge fields and their range check.
    assign in_src        = s_axis_tdata[FIELD_W-1:0];
    assign in_dst        = s_axis_tdata[2*FIELD_W-1:FIELD_W];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_good       = ({1'b0, in_src} < eff_n) && ({1'b0, in_dst} < eff_n);
    assign out_free      = !m_valid_reg || m_axis_tready;

    // Adjacency storage.
    gscc_adj_ram #(
        .MAX_NODES (MAX_NODES)
    ) u_adj_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ram_ctl),
        .rd_addr (ram_rd_addr),
        .wr_addr (src_reg),
        .wr_data (ram_wr_data),
        .rd_data (ram_rd_data)
    );

    // Shared row step for both walks.
    gscc_reach_unit #(
        .MAX_NODES (MAX_NODES)
    ) u_reach_unit (
        .row           (ram_rd_data),
        .row_idx       (proc_idx_reg),
        .node_mask     (node_mask),
        .seen_fwd      (seen_fwd_reg),
        .seen_rev      (seen_rev_reg),
        .seen_fwd_next (unit_fwd),
        .seen_rev_next (unit_rev),
        .changed       (unit_changed)
    );

    // The stored edge sets one more bit in the row read back from the RAM.
    assign ram_wr_data = ram_rd_data | (MAX_NODES'(1) << dst_reg);
    assign ram_rd_addr = (state_reg == ST_IDLE) ? in_src[NODE_W-1:0] : walk_idx_reg;

    // Sequencer next-state logic.
    always_comb
    begin
        state_next        = state_reg;
        node_count_next   = node_count_reg;
        src_next          = src_reg;
        dst_next          = dst_reg;
        last_next         = last_reg;
        bad_next          = bad_reg;
        walk_idx_next     = walk_idx_reg;
        proc_valid_next   = proc_valid_reg;
        proc_idx_next     = proc_idx_reg;
        changed_next      = changed_reg;
        seen_fwd_next     = seen_fwd_reg;
        seen_rev_next     = seen_rev_reg;
        cnt_idx_next      = cnt_idx_reg;
        fwd_cnt_next      = fwd_cnt_reg;
        rev_cnt_next      = rev_cnt_reg;
        m_data_next       = m_data_reg;
        m_valid_next      = m_valid_reg && !m_axis_tready;
        ram_ctl.rd_en     = 1'b0;
        ram_ctl.wr_en     = 1'b0;
        ram_ctl.clear_all = 1'b0;

        if (cfg_wr_en)
        begin
            node_count_next = cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    src_next  = in_src[NODE_W-1:0];
                    dst_next  = in_dst[NODE_W-1:0];
                    last_next = s_axis_tlast;
                    if (in_good)
                    begin
                        ram_ctl.rd_en = 1'b1;
                        state_next    = ST_WRITE;
                    end
                    else
                    begin
                        bad_next = 1'b1;
                        if (s_axis_tlast)
                        begin
                            state_next = ST_WALK;
                        end
                    end
                end
            end

            ST_WRITE:
            begin
                ram_ctl.wr_en = 1'b1;
                state_next    = last_reg ? ST_WALK : ST_IDLE;
            end

            ST_WALK:
            begin
                // Issue the next row read; process the row read in the previous cycle.
                ram_ctl.rd_en   = 1'b1;
                proc_valid_next = 1'b1;
                proc_idx_next   = walk_idx_reg;
                walk_idx_next   = (CNT_W'(walk_idx_reg) == last_idx) ? '0
                                                                    : walk_idx_reg + NODE_W'(1);
                if (proc_valid_reg)
                begin
                    seen_fwd_next = unit_fwd;
                    seen_rev_next = unit_rev;
                    if (CNT_W'(proc_idx_reg) == last_idx)
                    begin
                        // End of a sweep: stop once a whole sweep added nothing.
                        changed_next = 1'b0;
                        if (!(changed_reg || unit_changed))
                        begin
                            state_next   = ST_COUNT;
                            cnt_idx_next = '0;
                            fwd_cnt_next = '0;
                            rev_cnt_next = '0;
                        end
                    end
                    else
                    begin
                        changed_next = changed_reg || unit_changed;
                    end
                end
            end

            ST_COUNT:
            begin
                fwd_cnt_next = fwd_cnt_reg + CNT_W'(seen_fwd_reg[cnt_idx_reg]);
                rev_cnt_next = rev_cnt_reg + CNT_W'(seen_rev_reg[cnt_idx_reg]);
                cnt_idx_next = cnt_idx_reg + NODE_W'(1);
                if (CNT_W'(cnt_idx_reg) == last_idx)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                // Hand the result over and clear the graph for the next run.
                if (out_free)
                begin
                    m_valid_next      = 1'b1;
                    m_data_next       = {bad_reg, rev_cnt_reg, fwd_cnt_reg,
                                         (fwd_cnt_reg == eff_n) && (rev_cnt_reg == eff_n)};
                    ram_ctl.clear_all = 1'b1;
                    bad_next          = 1'b0;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Fresh walk state on entry to the walk.
        if ((state_next == ST_WALK) && (state_reg != ST_WALK))
        begin
            walk_idx_next   = '0;
            proc_valid_next = 1'b0;
            changed_next    = 1'b0;
            seen_fwd_next   = MAX_NODES'(1);
            seen_rev_next   = MAX_NODES'(1);
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= gscc_pkg::NODE_COUNT_RESET;
            src_reg        <= '0;
            dst_reg        <= '0;
            last_reg       <= 1'b0;
            bad_reg        <= 1'b0;
            walk_idx_reg   <= '0;
            proc_valid_reg <= 1'b0;
            proc_idx_reg   <= '0;
            changed_reg    <= 1'b0;
            seen_fwd_reg   <= '0;
            seen_rev_reg   <= '0;
            cnt_idx_reg    <= '0;
            fwd_cnt_reg    <= '0;
            rev_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            src_reg        <= src_next;
            dst_reg        <= dst_next;
            last_reg       <= last_next;
            bad_reg        <= bad_next;
            walk_idx_reg   <= walk_idx_next;
            proc_valid_reg <= proc_valid_next;
            proc_idx_reg   <= proc_idx_next;
            changed_reg    <= changed_next;
            seen_fwd_reg   <= seen_fwd_next;
            seen_rev_reg   <= seen_rev_next;
            cnt_idx_reg    <= cnt_idx_next;
            fwd_cnt_reg    <= fwd_cnt_next;
            rev_cnt_reg    <= rev_cnt_next;
            m_valid_reg    <= m_valid_next;
            m_data_reg     <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ----- hdl/gscc_checker.sv -----
// Port-level checks for the graph strong connectivity check unit, bound to the top level.
// Depends on gscc_pkg for port widths and on graph_strong_connectivity_check_unit.
module gscc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           s_axis_tlast,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [gscc_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Node 0 is always reached both ways.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:1] != 7'd0) && (m_axis_tdata[14:8] != 7'd0))
        else $error("reach count of zero");

    // A connected graph reports equal forward and reverse counts.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[7:1] == m_axis_tdata[14:8])
        else $error("connected result with unequal counts");

    // The last edge starts the check, so no edge is taken in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input ready right after the last edge");

    // An edge that is not the last produces no new result.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result after an edge that was not last");

endmodule

bind graph_strong_connectivity_check_unit gscc_checker u_gscc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/graph_strong_connectivity_check_unit_test.sv -----
// Self-checking testbench for the graph strong connectivity check unit.
// Streams directed edges with random gaps and stalls, predicts each verdict internally.
// Depends on gscc_pkg and graph_strong_connectivity_check_unit.
module graph_strong_connectivity_check_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODE_LIMIT       = gscc_pkg::MAX_NODES_DEF;
    localparam int EDGE_TARGET      = 1650;
    localparam int WATCHDOG_LIMIT   = 30000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int DRAIN_CYCLES     = 100;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int HOLD_PHASE       = 3;

    typedef logic [gscc_pkg::NODE_FIELD_W-1:0] node_t;
    typedef logic [gscc_pkg::COUNT_W-1:0]      count_t;
    typedef logic [NODE_LIMIT-1:0]             node_set_t;

    typedef struct {
        node_t src;
        node_t dst;
        logic  last;
    } edge_item_t;

    typedef struct {
        logic   connected;
        count_t fwd_count;
        count_t rev_count;
        logic   bad_seen;
    } verdict_t;

    typedef enum int {
        SHAPE_RING,
        SHAPE_BROKEN_RING,
        SHAPE_OUT_TREE,
        SHAPE_SCATTER,
        SHAPE_NOISE
    } graph_shape_t;

    // Block ports; every input starts at a known value.
    logic                               clk           = 1'b0;
    logic                               rst_n         = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    // tdata: [5:0] source_node, [11:6] dest_node, [15:12] zero.
    logic [gscc_pkg::S_TDATA_W-1:0]     s_axis_tdata  = '0;
    // tlast: last_edge.
    logic                               s_axis_tlast  = 1'b0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    // tdata: [0] is_strongly_connected, [7:1] forward_reached,
    //        [14:8] reverse_reached, [15] bad_edge_seen.
    logic [gscc_pkg::M_TDATA_W-1:0]     m_axis_tdata;
    logic                               cfg_wr_en     = 1'b0;
    count_t                             cfg_wr_data   = '0;

    // Shadow copy of the graph state used to predict verdicts.
    node_set_t  adj_rows [NODE_LIMIT];
    logic       bad_flag;
    count_t     node_count_shadow;

    // Edges waiting to be sent and verdicts waiting to be received.
    edge_item_t edge_backlog [$];
    edge_item_t edge_on_bus;
    verdict_t   pending_verdicts [$];
    int         edges_queued   = 0;
    int         edges_accepted = 0;

    // Handshake pacing on both sides.
    int         send_gap       = 0;
    int         send_calm      = 0;
    int         recv_stall     = 0;
    int         recv_calm      = 0;
    int         long_hold_left = 0;
    bit         long_hold_request = 1'b0;
    bit         long_hold_taken   = 1'b0;

    int         mismatch_count = 0;
    int         quiet_cycles   = 0;

    graph_strong_connectivity_check_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // Clock with a 2 ns period.
    always #1 clk = ~clk;

    // A register value of zero counts as one node, values above the maximum as the maximum.
    function automatic int effective_nodes(int setting);
        if (setting < 1)
            return 1;
        if (setting > NODE_LIMIT)
            return NODE_LIMIT;
        return setting;
    endfunction

    // Nodes reachable from node 0 following edges along the rows.
    function automatic node_set_t reach_from_root(int n, node_set_t mask);
        node_set_t seen;
        node_set_t prev;
        seen = node_set_t'(1);
        prev = '0;
        while (seen != prev)
        begin
            prev = seen;
            for (int i = 0; i < n; i++)
                if (prev[i])
                    seen |= adj_rows[i] & mask;
        end
        return seen;
    endfunction

    // Nodes that reach node 0, found by following edges backwards.
    function automatic node_set_t reach_to_root(int n);
        node_set_t seen;
        node_set_t prev;
        seen = node_set_t'(1);
        prev = '0;
        while (seen != prev)
        begin
            prev = seen;
            for (int j = 0; j < n; j++)
                if ((adj_rows[j] & prev) != '0)
                    seen[j] = 1'b1;
        end
        return seen;
    endfunction

    // Loads one accepted edge; a last edge closes the graph and queues its verdict.
    function automatic void absorb_edge(edge_item_t e);
        int        n;
        node_set_t mask;
        node_set_t fwd_set;
        node_set_t rev_set;
        verdict_t  v;
        n    = effective_nodes(int'(node_count_shadow));
        mask = (n >= NODE_LIMIT) ? '1 : ((node_set_t'(1) << n) - node_set_t'(1));
        if (int'(e.src) < n && int'(e.dst) < n)
            adj_rows[e.src][e.dst] = 1'b1;
        else
            bad_flag = 1'b1;
        if (!e.last)
            return;
        fwd_set     = reach_from_root(n, mask) & mask;
        rev_set     = reach_to_root(n) & mask;
        v.fwd_count = count_t'($countones(fwd_set));
        v.rev_count = count_t'($countones(rev_set));
        v.connected = (int'(v.fwd_count) == n) && (int'(v.rev_count) == n);
        v.bad_seen  = bad_flag;
        pending_verdicts = {pending_verdicts, v};
        for (int i = 0; i < NODE_LIMIT; i++)
            adj_rows[i] = '0;
        bad_flag = 1'b0;
    endfunction

    function automatic void compare_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Idle gaps: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void queue_edge(int src, int dst, bit last);
        edge_item_t e;
        e.src  = node_t'(src);
        e.dst  = node_t'(dst);
        e.last = last;
        edge_backlog = {edge_backlog, e};
        edges_queued++;
    endfunction

    // Builds one graph of the given shape over n nodes, shuffles its edges and
    // marks the final one as last. Edges are held as src * 64 + dst.
    function automatic void queue_graph(int n, graph_shape_t shape, bit with_bad);
        int order [$];
        int pairs [$];
        int k;
        int j;
        int tmp;
        int bad_node;
        int good_node;
        for (k = 0; k < n; k++)
            order = {order, k};
        for (k = n - 1; k > 0; k--)
        begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        case (shape)
            SHAPE_RING, SHAPE_BROKEN_RING:
            begin
                for (k = 0; k < n; k++)
                    pairs = {pairs, order[k] * 64 + order[(k + 1) % n]};
                if (shape == SHAPE_BROKEN_RING && n > 1)
                    pairs.delete($urandom_range(0, n - 1));
                repeat ($urandom_range(0, n / 2))
                    pairs = {pairs,
                             int'($urandom_range(0, n - 1) * 64 + $urandom_range(0, n - 1))};
            end
            SHAPE_OUT_TREE:
            begin
                for (k = 1; k < n; k++)
                    pairs = {pairs, int'($urandom_range(0, k - 1) * 64 + k)};
            end
            SHAPE_SCATTER:
            begin
                repeat ($urandom_range(1, 2 * n))
                    pairs = {pairs,
                             int'($urandom_range(0, n - 1) * 64 + $urandom_range(0, n - 1))};
            end
            default:
            begin
                repeat ($urandom_range(1, 8))
                    pairs = {pairs, int'($urandom_range(0, 63) * 64 + $urandom_range(0, 63))};
            end
        endcase
        // Edges naming a node beyond the count are dropped by the block and flagged.
        if (with_bad && n < NODE_LIMIT)
        begin
            repeat ($urandom_range(1, 2))
            begin
                bad_node  = $urandom_range(n, 63);
                good_node = $urandom_range(0, n - 1);
                case ($urandom_range(0, 2))
                    0:       pairs = {pairs, bad_node * 64 + good_node};
                    1:       pairs = {pairs, good_node * 64 + bad_node};
                    default: pairs = {pairs, int'(bad_node * 64 + $urandom_range(n, 63))};
                endcase
            end
        end
        if (pairs.size() == 0)
            pairs = {pairs, 0};
        for (k = pairs.size() - 1; k > 0; k--)
        begin
            j        = $urandom_range(0, k);
            tmp      = pairs[k];
            pairs[k] = pairs[j];
            pairs[j] = tmp;
        end
        for (k = 0; k < pairs.size(); k++)
            queue_edge(pairs[k] / 64, pairs[k] % 64, k == pairs.size() - 1);
    endfunction

    // Waits until every edge has been taken and every verdict has arrived,
    // then lets a stored edge finish its row write.
    task automatic wait_until_idle();
        while (edges_accepted != edges_queued || pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_node_count(int value);
        wait_until_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count_t'(value);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        node_count_shadow = count_t'(value);
    endtask

    // Edge sender: predicts on each accepted transfer, then offers the next edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                absorb_edge(edge_on_bus);
                edges_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0 || edge_backlog.size() == 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    if (send_gap > 0)
                        send_gap--;
                end
                else
                begin
                    edge_on_bus = edge_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'b0000, edge_on_bus.dst, edge_on_bus.src};
                    s_axis_tlast  <= edge_on_bus.last;
                    if (send_calm > 0)
                    begin
                        send_calm--;
                        send_gap = 0;
                    end
                    else
                    begin
                        send_gap = pick_gap();
                        if ($urandom_range(0, 99) < 2)
                            send_calm = $urandom_range(30, 120);
                    end
                end
            end
        end
    end

    // Result receiver: checks each transfer against the oldest verdict and paces tready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin : collect
            verdict_t want;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $error("result transfer 0x%04h with no verdict pending", m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    compare_field("is_strongly_connected", want.connected, m_axis_tdata[0]);
                    compare_field("forward_reached", want.fwd_count, m_axis_tdata[7:1]);
                    compare_field("reverse_reached", want.rev_count, m_axis_tdata[14:8]);
                    compare_field("bad_edge_seen", want.bad_seen, m_axis_tdata[15]);
                end
            end
            if (long_hold_request && !long_hold_taken)
            begin
                long_hold_taken = 1'b1;
                long_hold_left  = LONG_HOLD_CYCLES;
            end
            if (long_hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                long_hold_left--;
            end
            else if (recv_stall > 0)
            begin
                m_axis_tready <= 1'b0;
                recv_stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (recv_calm > 0)
                    recv_calm--;
                else
                begin
                    recv_stall = pick_gap();
                    if ($urandom_range(0, 99) < 2)
                        recv_calm = $urandom_range(30, 120);
                end
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Stimulus: directed cases first, then random phases each under one node count.
    initial
    begin : stimulus
        int           phase;
        int           r;
        int           count_setting;
        int           n;
        int           graphs;
        graph_shape_t shape;
        phase = 0;
        for (int i = 0; i < NODE_LIMIT; i++)
            adj_rows[i] = '0;
        bad_flag          = 1'b0;
        node_count_shadow = gscc_pkg::NODE_COUNT_RESET;

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset count of 64: a lone edge to the top node, then duplicates and a self loop.
        queue_edge(0, 63, 1'b1);
        queue_edge(63, 0, 1'b0);
        queue_edge(63, 0, 1'b0);
        queue_edge(0, 63, 1'b0);
        queue_edge(5, 5, 1'b1);

        // Two nodes: a two-way loop connects; edges beyond the count are flagged,
        // including on the last edge itself.
        write_node_count(2);
        queue_edge(0, 1, 1'b0);
        queue_edge(1, 0, 1'b0);
        queue_edge(0, 1, 1'b0);
        queue_edge(1, 1, 1'b1);
        queue_edge(63, 0, 1'b1);
        queue_edge(0, 62, 1'b0);
        queue_edge(1, 0, 1'b1);

        // A count of zero behaves as a single node.
        write_node_count(0);
        queue_edge(0, 0, 1'b1);
        queue_edge(1, 0, 1'b1);

        // A count above the maximum behaves as the maximum.
        write_node_count(127);
        queue_edge(0, 63, 1'b0);
        queue_edge(63, 0, 1'b1);

        // Count lowered while a graph is half loaded: bits above it are ignored.
        write_node_count(3);
        queue_edge(0, 1, 1'b0);
        queue_edge(1, 2, 1'b0);
        queue_edge(2, 0, 1'b0);
        write_node_count(2);
        queue_edge(1, 0, 1'b1);

        // Random phases; most counts are small so the walks stay short.
        while (edges_queued < EDGE_TARGET)
        begin
            phase++;
            r = $urandom_range(0, 99);
            if (r < 40)
                count_setting = $urandom_range(1, 8);
            else if (r < 65)
                count_setting = $urandom_range(9, 24);
            else if (r < 75)
                count_setting = $urandom_range(25, 63);
            else if (r < 83)
                count_setting = 64;
            else if (r < 88)
                count_setting = 0;
            else if (r < 95)
                count_setting = $urandom_range(65, 126);
            else
                count_setting = 127;
            if (phase == HOLD_PHASE)
                count_setting = 4;
            write_node_count(count_setting);
            n      = effective_nodes(count_setting);
            graphs = (phase == HOLD_PHASE) ? 40 : $urandom_range(3, 12);
            repeat (graphs)
            begin
                // Stop adding graphs once the edge budget is reached.
                if (edges_queued < EDGE_TARGET || phase == HOLD_PHASE)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 30)
                        shape = SHAPE_RING;
                    else if (r < 45)
                        shape = SHAPE_BROKEN_RING;
                    else if (r < 60)
                        shape = SHAPE_OUT_TREE;
                    else if (r < 85)
                        shape = SHAPE_SCATTER;
                    else
                        shape = SHAPE_NOISE;
                    queue_graph(n, shape, $urandom_range(0, 99) < 20);
                end
            end
            // Many short graphs queued: hold results back so the block backs up.
            if (phase == HOLD_PHASE)
                long_hold_request = 1'b1;
            // Now and then leave a graph open across the next count change.
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 4))
                    queue_edge($urandom_range(0, 63), $urandom_range(0, 63), 1'b0);
        end

        wait_until_idle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
